// ===== sv/gdfs_pkg.sv =====
// Shared types and constants of the grid depth-first search block.
package gdfs_pkg;

  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLUMNS_DEF = 64;

  localparam int OP_W     = 2;
  localparam int COORD_W  = 7;
  localparam int TIME_W   = 14;
  localparam int COLOUR_W = 2;
  localparam int PDIR_W   = 3;
  localparam int DIR_W    = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [COORD_W-1:0] GRID_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT = 1'b0,
    REG_WIDTH  = 1'b1
  } reg_idx_t;

  localparam logic [COLOUR_W-1:0] COL_UNVISITED = 2'd0;
  localparam logic [COLOUR_W-1:0] COL_ACTIVE    = 2'd1;
  localparam logic [COLOUR_W-1:0] COL_FINISHED  = 2'd2;

  localparam logic [PDIR_W-1:0] PD_NONE  = 3'd0;
  localparam logic [PDIR_W-1:0] PD_ABOVE = 3'd1;
  localparam logic [PDIR_W-1:0] PD_BELOW = 3'd2;
  localparam logic [PDIR_W-1:0] PD_LEFT  = 3'd3;
  localparam logic [PDIR_W-1:0] PD_RIGHT = 3'd4;

  localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
  localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDOUT,
    S_ROOT,
    S_RCHK,
    S_STEP,
    S_NCHK,
    S_POP
  } state_t;

endpackage

// ===== sv/gdfs_if.sv =====
// Channel interfaces: request, response and configuration write.
interface gdfs_req_if;
  logic                         valid;
  logic                         ready;
  logic [gdfs_pkg::OP_W-1:0]    operation;
  logic [gdfs_pkg::COORD_W-1:0] row;
  logic [gdfs_pkg::COORD_W-1:0] column;
  logic                         cell_open;
  modport source (output valid, operation, row, column, cell_open, input ready);
  modport sink   (input valid, operation, row, column, cell_open, output ready);
endinterface

interface gdfs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          done_res;
  logic [gdfs_pkg::COLOUR_W-1:0] cell_colour;
  logic [gdfs_pkg::TIME_W-1:0]   discover_time;
  logic [gdfs_pkg::TIME_W-1:0]   finish_time;
  logic [gdfs_pkg::COORD_W-1:0]  parent_row;
  logic [gdfs_pkg::COORD_W-1:0]  parent_column;
  modport source (output valid, done_res, cell_colour, discover_time, finish_time,
                  parent_row, parent_column, input ready);
  modport sink   (input valid, done_res, cell_colour, discover_time, finish_time,
                  parent_row, parent_column, output ready);
endinterface

interface gdfs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gdfs_pkg::CFG_IDX_W-1:0]  index;
  logic [gdfs_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/gdfs_ram.sv =====
// Generic simple dual-port RAM with registered read.
module gdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/grid_depth_first_search.sv =====
// Top level of the grid depth-first search block.
//
//   channel  dir  handshake     contents
//   req      in   valid/ready   operation, row, column, cell_open
//   rsp      out  valid/ready   done_res, colour, times, parent
//   cfg      in   valid/ready   index (0 height, 1 width), data
//
// Write and unused items are answered from registers, read items through the registered
// RAM read. A run first clears the result RAMs, then tests each root in S_ROOT and S_RCHK,
// each neighbour in S_STEP and S_NCHK and finishes each cell in S_STEP, popping in S_POP,
// as each RAM has a single read port.
// After reset the block clears the result RAMs and takes no item while it does so;
// cfg writes are taken at all times.
// A stalled rsp holds its item; req is taken while the last result is leaving.
module grid_depth_first_search #(
  parameter int MAX_ROWS    = gdfs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = gdfs_pkg::MAX_COLUMNS_DEF
) (
  input logic           clk,
  input logic           rst,
  gdfs_req_if.sink      req,
  gdfs_rsp_if.source    rsp,
  gdfs_cfg_if.sink      cfg
);
  localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RCW   = RW + 1;
  localparam int CCW   = CW + 1;
  localparam int SW    = RW + CW + gdfs_pkg::DIR_W;
  localparam int SPW   = AW + 1;
  localparam int TW    = gdfs_pkg::TIME_W;
  localparam int XW    = gdfs_pkg::COORD_W;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    cell_addr = AW'(int'(r) * MAX_COLUMNS + int'(c));
  endfunction

  gdfs_pkg::state_t state, state_next;

  logic [XW-1:0]  grid_h, grid_w;
  logic [RCW-1:0] h_eff;
  logic [CCW-1:0] w_eff;
  logic           clear_run;
  logic [AW-1:0]  clr_addr;
  logic [RCW-1:0] scan_r;
  logic [CCW-1:0] scan_c;
  logic [RW-1:0]  top_r, nb_r, next_r;
  logic [CW-1:0]  top_c, nb_c, next_c;
  logic [gdfs_pkg::DIR_W-1:0]  top_dir;
  logic [gdfs_pkg::PDIR_W-1:0] nb_back, next_back;
  logic           nb_ok;
  logic [SPW-1:0] sp;
  logic [TW-1:0]  tcount;
  logic [XW-1:0]  rd_row, rd_col;
  logic           rd_ok;
  logic           req_ok;
  logic           req_fire, rsp_free;
  logic           item_load;

  logic ovalid, odone;
  logic [gdfs_pkg::COLOUR_W-1:0] ocolour;
  logic [TW-1:0] odisc, ofin;
  logic [XW-1:0] oprow, opcol;

  // RAM ports
  logic          open_we, col_we, disc_we, fin_we, pd_we, stk_we;
  logic [AW-1:0] open_waddr, res_waddr, res_raddr, stk_waddr, stk_raddr;
  logic          open_wdata, open_rdata;
  logic [gdfs_pkg::COLOUR_W-1:0] col_wdata, col_rdata;
  logic [TW-1:0] disc_wdata, disc_rdata, fin_wdata, fin_rdata;
  logic [gdfs_pkg::PDIR_W-1:0] pd_wdata, pd_rdata;
  logic [SW-1:0] stk_wdata, stk_rdata;
  logic [TW-1:0] tnext;

  assign tnext = tcount + TW'(1);
  assign h_eff = (int'(grid_h) > MAX_ROWS)    ? RCW'(MAX_ROWS)    : RCW'(grid_h);
  assign w_eff = (int'(grid_w) > MAX_COLUMNS) ? CCW'(MAX_COLUMNS) : CCW'(grid_w);

  assign rsp_free  = !ovalid || rsp.ready;
  assign req.ready = (state == gdfs_pkg::S_IDLE) && rsp_free;
  assign req_fire  = req.valid && req.ready;
  assign item_load = req_fire &&
                     (gdfs_pkg::op_t'(req.operation) == gdfs_pkg::OP_WRITE ||
                      gdfs_pkg::op_t'(req.operation) == gdfs_pkg::OP_NONE);
  assign cfg.ready = 1'b1;
  assign req_ok    = (req.row >= XW'(1)) && (int'(req.row) <= MAX_ROWS) &&
                     (req.column >= XW'(1)) && (int'(req.column) <= MAX_COLUMNS);

  always_comb begin
    nb_ok   = 1'b0;
    nb_r    = top_r;
    nb_c    = top_c;
    nb_back = gdfs_pkg::PD_NONE;
    case (top_dir)
      gdfs_pkg::DIR_UP: begin
        nb_ok   = top_r != '0;
        nb_r    = top_r - RW'(1);
        nb_back = gdfs_pkg::PD_BELOW;
      end
      gdfs_pkg::DIR_DOWN: begin
        nb_ok   = (RCW'(top_r) + RCW'(1)) < h_eff;
        nb_r    = top_r + RW'(1);
        nb_back = gdfs_pkg::PD_ABOVE;
      end
      gdfs_pkg::DIR_LEFT: begin
        nb_ok   = top_c != '0;
        nb_c    = top_c - CW'(1);
        nb_back = gdfs_pkg::PD_RIGHT;
      end
      gdfs_pkg::DIR_RIGHT: begin
        nb_ok   = (CCW'(top_c) + CCW'(1)) < w_eff;
        nb_c    = top_c + CW'(1);
        nb_back = gdfs_pkg::PD_LEFT;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gdfs_pkg::S_CLEAR: begin
        if (clr_addr == AW'(CELLS - 1)) begin
          state_next = clear_run ? gdfs_pkg::S_ROOT : gdfs_pkg::S_IDLE;
        end
      end
      gdfs_pkg::S_IDLE: begin
        if (req_fire) begin
          case (gdfs_pkg::op_t'(req.operation))
            gdfs_pkg::OP_RUN:  state_next = gdfs_pkg::S_CLEAR;
            gdfs_pkg::OP_READ: state_next = gdfs_pkg::S_RDOUT;
            default:           state_next = gdfs_pkg::S_IDLE;
          endcase
        end
      end
      gdfs_pkg::S_RDOUT: state_next = gdfs_pkg::S_IDLE;
      gdfs_pkg::S_ROOT: begin
        if (scan_r >= h_eff) begin
          state_next = gdfs_pkg::S_IDLE;
        end else if (scan_c < w_eff) begin
          state_next = gdfs_pkg::S_RCHK;
        end
      end
      gdfs_pkg::S_RCHK: begin
        state_next = (open_rdata && col_rdata == gdfs_pkg::COL_UNVISITED) ?
                     gdfs_pkg::S_STEP : gdfs_pkg::S_ROOT;
      end
      gdfs_pkg::S_STEP: begin
        if (top_dir == gdfs_pkg::DIR_DONE) begin
          state_next = (sp > SPW'(1)) ? gdfs_pkg::S_POP : gdfs_pkg::S_ROOT;
        end else if (nb_ok) begin
          state_next = gdfs_pkg::S_NCHK;
        end
      end
      gdfs_pkg::S_NCHK: state_next = gdfs_pkg::S_STEP;
      gdfs_pkg::S_POP:  state_next = gdfs_pkg::S_STEP;
      default:          state_next = gdfs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    open_we    = req_fire && gdfs_pkg::op_t'(req.operation) == gdfs_pkg::OP_WRITE && req_ok;
    open_waddr = cell_addr(RW'(req.row - XW'(1)), CW'(req.column - XW'(1)));
    open_wdata = req.cell_open;
    col_we     = 1'b0;
    disc_we    = 1'b0;
    fin_we     = 1'b0;
    pd_we      = 1'b0;
    col_wdata  = gdfs_pkg::COL_UNVISITED;
    disc_wdata = '0;
    fin_wdata  = '0;
    pd_wdata   = gdfs_pkg::PD_NONE;
    res_waddr  = clr_addr;
    res_raddr  = open_waddr;
    stk_we     = 1'b0;
    stk_waddr  = AW'(sp - SPW'(1));
    stk_wdata  = {top_r, top_c, top_dir};
    stk_raddr  = AW'(sp - SPW'(2));
    unique case (state)
      gdfs_pkg::S_CLEAR: begin
        col_we  = 1'b1;
        disc_we = 1'b1;
        fin_we  = 1'b1;
        pd_we   = 1'b1;
      end
      gdfs_pkg::S_ROOT: res_raddr = cell_addr(RW'(scan_r), CW'(scan_c));
      gdfs_pkg::S_RCHK: begin
        res_waddr  = cell_addr(RW'(scan_r), CW'(scan_c));
        col_we     = open_rdata && col_rdata == gdfs_pkg::COL_UNVISITED;
        disc_we    = col_we;
        col_wdata  = gdfs_pkg::COL_ACTIVE;
        disc_wdata = tnext;
      end
      gdfs_pkg::S_STEP: begin
        res_raddr = cell_addr(nb_r, nb_c);
        res_waddr = cell_addr(top_r, top_c);
        if (top_dir == gdfs_pkg::DIR_DONE) begin
          col_we    = 1'b1;
          fin_we    = 1'b1;
          col_wdata = gdfs_pkg::COL_FINISHED;
          fin_wdata = tnext;
        end
      end
      gdfs_pkg::S_NCHK: begin
        res_waddr  = cell_addr(next_r, next_c);
        col_we     = open_rdata && col_rdata == gdfs_pkg::COL_UNVISITED;
        disc_we    = col_we;
        pd_we      = col_we;
        stk_we     = col_we;
        col_wdata  = gdfs_pkg::COL_ACTIVE;
        disc_wdata = tnext;
        pd_wdata   = next_back;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gdfs_pkg::S_CLEAR;
      clear_run <= 1'b0;
      clr_addr  <= '0;
      grid_h    <= gdfs_pkg::GRID_RESET;
      grid_w    <= gdfs_pkg::GRID_RESET;
      ovalid    <= 1'b0;
      sp        <= '0;
      tcount    <= '0;
      scan_r    <= '0;
      scan_c    <= '0;
      top_dir   <= gdfs_pkg::DIR_UP;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        unique case (gdfs_pkg::reg_idx_t'(cfg.index))
          gdfs_pkg::REG_HEIGHT: grid_h <= cfg.data;
          gdfs_pkg::REG_WIDTH:  grid_w <= cfg.data;
          default: ;
        endcase
      end
      if (ovalid && rsp.ready && !item_load) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        gdfs_pkg::S_CLEAR: clr_addr <= clr_addr + AW'(1);
        gdfs_pkg::S_IDLE: begin
          if (req_fire) begin
            rd_row <= req.row;
            rd_col <= req.column;
            rd_ok  <= req_ok;
            case (gdfs_pkg::op_t'(req.operation))
              gdfs_pkg::OP_RUN: begin
                clear_run <= 1'b1;
                clr_addr  <= '0;
                tcount    <= '0;
                sp        <= '0;
                scan_r    <= '0;
                scan_c    <= '0;
              end
              gdfs_pkg::OP_READ: ;
              default: begin
                ovalid <= 1'b1;
                odone  <= gdfs_pkg::op_t'(req.operation) == gdfs_pkg::OP_WRITE;
                ocolour <= gdfs_pkg::COL_UNVISITED;
                odisc  <= '0;
                ofin   <= '0;
                oprow  <= '0;
                opcol  <= '0;
              end
            endcase
          end
        end
        gdfs_pkg::S_RDOUT: begin
          ovalid  <= 1'b1;
          odone   <= 1'b1;
          ocolour <= rd_ok ? col_rdata : gdfs_pkg::COL_UNVISITED;
          odisc   <= rd_ok ? disc_rdata : '0;
          ofin    <= rd_ok ? fin_rdata : '0;
          case (rd_ok ? pd_rdata : gdfs_pkg::PD_NONE)
            gdfs_pkg::PD_ABOVE: begin
              oprow <= rd_row - XW'(1);
              opcol <= rd_col;
            end
            gdfs_pkg::PD_BELOW: begin
              oprow <= rd_row + XW'(1);
              opcol <= rd_col;
            end
            gdfs_pkg::PD_LEFT: begin
              oprow <= rd_row;
              opcol <= rd_col - XW'(1);
            end
            gdfs_pkg::PD_RIGHT: begin
              oprow <= rd_row;
              opcol <= rd_col + XW'(1);
            end
            default: begin
              oprow <= '0;
              opcol <= '0;
            end
          endcase
        end
        gdfs_pkg::S_ROOT: begin
          if (scan_r >= h_eff) begin
            clear_run <= 1'b0;
            ovalid    <= 1'b1;
            odone     <= 1'b1;
            ocolour   <= gdfs_pkg::COL_UNVISITED;
            odisc     <= '0;
            ofin      <= '0;
            oprow     <= '0;
            opcol     <= '0;
          end else if (scan_c >= w_eff) begin
            scan_c <= '0;
            scan_r <= scan_r + RCW'(1);
          end
        end
        gdfs_pkg::S_RCHK: begin
          if (open_rdata && col_rdata == gdfs_pkg::COL_UNVISITED) begin
            tcount  <= tnext;
            top_r   <= RW'(scan_r);
            top_c   <= CW'(scan_c);
            top_dir <= gdfs_pkg::DIR_UP;
            sp      <= SPW'(1);
          end else begin
            scan_c <= scan_c + CCW'(1);
          end
        end
        gdfs_pkg::S_STEP: begin
          if (top_dir == gdfs_pkg::DIR_DONE) begin
            tcount <= tnext;
            sp     <= sp - SPW'(1);
          end else begin
            top_dir   <= top_dir + gdfs_pkg::DIR_W'(1);
            next_r    <= nb_r;
            next_c    <= nb_c;
            next_back <= nb_back;
          end
        end
        gdfs_pkg::S_NCHK: begin
          if (open_rdata && col_rdata == gdfs_pkg::COL_UNVISITED) begin
            tcount  <= tnext;
            top_r   <= next_r;
            top_c   <= next_c;
            top_dir <= gdfs_pkg::DIR_UP;
            sp      <= sp + SPW'(1);
          end
        end
        gdfs_pkg::S_POP: begin
          {top_r, top_c, top_dir} <= stk_rdata;
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid         = ovalid;
  assign rsp.done_res      = odone;
  assign rsp.cell_colour   = ocolour;
  assign rsp.discover_time = odisc;
  assign rsp.finish_time   = ofin;
  assign rsp.parent_row    = oprow;
  assign rsp.parent_column = opcol;

  gdfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_open (
    .clk, .we(open_we), .waddr(open_waddr), .wdata(open_wdata),
    .raddr(res_raddr), .rdata(open_rdata));
  gdfs_ram #(.WIDTH(gdfs_pkg::COLOUR_W), .DEPTH(CELLS)) u_colour (
    .clk, .we(col_we), .waddr(res_waddr), .wdata(col_wdata),
    .raddr(res_raddr), .rdata(col_rdata));
  gdfs_ram #(.WIDTH(TW), .DEPTH(CELLS)) u_disc (
    .clk, .we(disc_we), .waddr(res_waddr), .wdata(disc_wdata),
    .raddr(res_raddr), .rdata(disc_rdata));
  gdfs_ram #(.WIDTH(TW), .DEPTH(CELLS)) u_fin (
    .clk, .we(fin_we), .waddr(res_waddr), .wdata(fin_wdata),
    .raddr(res_raddr), .rdata(fin_rdata));
  gdfs_ram #(.WIDTH(gdfs_pkg::PDIR_W), .DEPTH(CELLS)) u_pdir (
    .clk, .we(pd_we), .waddr(res_waddr), .wdata(pd_wdata),
    .raddr(res_raddr), .rdata(pd_rdata));
  gdfs_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));

endmodule

// ===== sv/gdfs_checker.sv =====
// Port checker for the grid depth-first search block, bound to the top level.
module gdfs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          done_res,
  input logic [gdfs_pkg::COLOUR_W-1:0] cell_colour,
  input logic [gdfs_pkg::TIME_W-1:0]   discover_time,
  input logic [gdfs_pkg::TIME_W-1:0]   finish_time,
  input logic [gdfs_pkg::COORD_W-1:0]  parent_row,
  input logic [gdfs_pkg::COORD_W-1:0]  parent_column
);
  a_rst_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_not_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !done_res |-> cell_colour == gdfs_pkg::COL_UNVISITED &&
      discover_time == '0 && finish_time == '0)
    else $error("unused operation returned data");

  a_unvisited: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && cell_colour == gdfs_pkg::COL_UNVISITED |->
      discover_time == '0 && finish_time == '0 &&
      parent_row == '0 && parent_column == '0)
    else $error("unvisited cell carries search data");
endmodule

bind grid_depth_first_search gdfs_checker u_gdfs_checker (
  .clk(clk),
  .rst(rst),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .done_res(rsp.done_res),
  .cell_colour(rsp.cell_colour),
  .discover_time(rsp.discover_time),
  .finish_time(rsp.finish_time),
  .parent_row(rsp.parent_row),
  .parent_column(rsp.parent_column)
);
